@@ rtl/cbs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the circular buffer with search.
// No dependencies; used by every module of the block.
package cbs_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int RING_W      = 5;
    localparam int VALUE_W     = 32;
    localparam int OCC_W       = 4;
    localparam logic [RING_W-1:0] RING_RST = 5'd16;
    localparam logic [RING_W-1:0] RING_MIN = 5'd2;

    // operation codes
    localparam logic [1:0] FN_ADD    = 2'd0;
    localparam logic [1:0] FN_POP    = 2'd1;
    localparam logic [1:0] FN_FIND   = 2'd2;
    localparam logic [1:0] FN_REMOVE = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [1:0]                status;
        logic [OCC_W-1:0]          occupancy;
    } t_result;

endpackage

@@ rtl/cbs_ram.sv @@
`timescale 1ns / 1ps
// Entry store of the circular buffer: one write port, one read port,
// registered read data. Depends on cbs_pkg.
module cbs_ram #(
    parameter int DEPTH = cbs_pkg::DEPTH_DEF,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [IW-1:0]                i_waddr,
    input  logic [cbs_pkg::VALUE_W-1:0]  i_wdata,
    input  logic [IW-1:0]                i_raddr,
    output logic [cbs_pkg::VALUE_W-1:0]  o_rdata
);

    logic [cbs_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic [cbs_pkg::VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/cbs_engine.sv @@
`timescale 1ns / 1ps
// Queue sequencer: head/tail pointers, scan and compaction over the entry
// store. Depends on cbs_pkg and cbs_ram.
module cbs_engine #(
    parameter int DEPTH = cbs_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_clr,
    input  logic [cbs_pkg::RING_W-1:0]          i_ring,
    input  logic                                i_start,
    input  logic [1:0]                          i_func,
    input  logic signed [cbs_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_idle,
    output logic                                o_done,
    input  logic                                i_take,
    output cbs_pkg::t_result                    o_result
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = IW + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    function automatic logic [IW-1:0] f_adv(input logic [IW-1:0] i, input logic [PW-1:0] n);
        logic [PW-1:0] s;
        s = {1'b0, i} + PW'(1);
        f_adv = (s == n) ? '0 : s[IW-1:0];
    endfunction

    logic [1:0]                         r_state, n_state;
    logic [IW-1:0]                      r_head, n_head;
    logic [IW-1:0]                      r_tail, n_tail;
    logic [IW-1:0]                      r_rd, n_rd;
    logic [IW-1:0]                      r_wr, n_wr;
    logic [PW-1:0]                      r_iss, n_iss;
    logic                               r_dv, n_dv;
    logic                               r_hit, n_hit;
    logic [1:0]                         r_func, n_func;
    logic signed [cbs_pkg::VALUE_W-1:0] r_value, n_value;
    logic signed [cbs_pkg::VALUE_W-1:0] r_res, n_res;
    logic [1:0]                         r_status, n_status;

    logic [PW-1:0]                      w_n;
    logic [PW-1:0]                      w_cnt;
    logic                               w_we;
    logic [IW-1:0]                      w_waddr;
    logic [cbs_pkg::VALUE_W-1:0]        w_wdata;
    logic [IW-1:0]                      w_raddr;
    logic [cbs_pkg::VALUE_W-1:0]        w_rdata;

    // ring size is clamped upstream, so it never exceeds DEPTH
    assign w_n   = PW'(i_ring);
    assign w_cnt = (r_tail >= r_head) ? ({1'b0, r_tail} - {1'b0, r_head})
                                      : ({1'b0, r_tail} + w_n - {1'b0, r_head});

    // Compaction writes trail the scan reads by at least one entry, and the
    // queue never fills the ring, so a read and a write never hit one slot.
    cbs_ram #(.DEPTH(DEPTH), .IW(IW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_rd     = r_rd;
        n_wr     = r_wr;
        n_iss    = r_iss;
        n_dv     = r_dv;
        n_hit    = r_hit;
        n_func   = r_func;
        n_value  = r_value;
        n_res    = r_res;
        n_status = r_status;
        w_we     = 1'b0;
        w_waddr  = r_tail;
        w_wdata  = i_value;
        w_raddr  = r_rd;

        unique case (r_state)
            S_IDLE: begin
                if (i_clr) begin
                    n_head = '0;
                    n_tail = '0;
                end else if (i_start) begin
                    n_func  = i_func;
                    n_value = i_value;
                    unique case (i_func)
                        cbs_pkg::FN_ADD: begin
                            if (f_adv(r_tail, w_n) == r_head) begin
                                n_status = cbs_pkg::ST_FULL;
                                n_res    = '0;
                            end else begin
                                w_we     = 1'b1;
                                n_tail   = f_adv(r_tail, w_n);
                                n_status = cbs_pkg::ST_OK;
                                n_res    = i_value;
                            end
                            n_state = S_DONE;
                        end
                        cbs_pkg::FN_POP: begin
                            if (r_head == r_tail) begin
                                n_status = cbs_pkg::ST_EMPTY;
                                n_res    = '0;
                                n_state  = S_DONE;
                            end else begin
                                w_raddr  = r_head;
                                n_head   = f_adv(r_head, w_n);
                                n_status = cbs_pkg::ST_OK;
                                n_state  = S_POP;
                            end
                        end
                        default: begin
                            n_rd    = r_head;
                            n_wr    = r_head;
                            n_iss   = '0;
                            n_dv    = 1'b0;
                            n_hit   = 1'b0;
                            n_state = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_dv = 1'b0;
                if (r_iss != w_cnt) begin
                    w_raddr = r_rd;
                    n_rd    = f_adv(r_rd, w_n);
                    n_iss   = r_iss + PW'(1);
                    n_dv    = 1'b1;
                end
                if (r_dv) begin
                    if (w_rdata == r_value) begin
                        n_hit = 1'b1;
                    end else if (r_func == cbs_pkg::FN_REMOVE) begin
                        w_we    = 1'b1;
                        w_waddr = r_wr;
                        w_wdata = w_rdata;
                        n_wr    = f_adv(r_wr, w_n);
                    end
                end
                if ((r_iss == w_cnt) && !r_dv) begin
                    if ((r_func == cbs_pkg::FN_REMOVE) && r_hit) begin
                        n_tail = r_wr;
                    end
                    n_status = r_hit ? cbs_pkg::ST_OK : cbs_pkg::ST_NOTFOUND;
                    n_res    = r_hit ? r_value : '0;
                    n_state  = S_DONE;
                end
            end
            S_POP: begin
                n_res   = $signed(w_rdata);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_dv    <= n_dv;
        end
        r_rd     <= n_rd;
        r_wr     <= n_wr;
        r_iss    <= n_iss;
        r_hit    <= n_hit;
        r_func   <= n_func;
        r_value  <= n_value;
        r_res    <= n_res;
        r_status <= n_status;
    end

    assign o_idle              = (r_state == S_IDLE);
    assign o_done              = (r_state == S_DONE);
    assign o_result.value      = r_res;
    assign o_result.status     = r_status;
    assign o_result.occupancy  = cbs_pkg::OCC_W'(w_cnt);

endmodule

@@ rtl/circular_buffer_with_search.sv @@
`timescale 1ns / 1ps
// Circular buffer with search: ring-buffer queue of signed 32-bit words.
// Add and a failed pop go straight to the result state; a pop first waits for
// its entry-store read; contains/remove-value first scan the queue:
// one entry-store read per stored entry, walked head to tail.
// The next word is taken only after the engine hands its result to the output register and
// returns to idle; a held result stalls the engine.
// Reset empties the queue and sets max_length to 16; the store is not cleared.
module circular_buffer_with_search #(
    parameter int DEPTH = cbs_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration: max_length
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cbs_pkg::RING_W-1:0]    i_cfg_data,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,  // [31:0] value
    input  logic [1:0]                    s_axis_tuser,  // [1:0] func
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [39:0]                   m_axis_tdata,  // [31:0] result_value, [35:32] occupancy
    output logic [1:0]                    m_axis_tuser   // [1:0] status
);

    logic [cbs_pkg::RING_W-1:0] r_max;
    logic [cbs_pkg::RING_W-1:0] w_ring;
    logic                       w_cfg_wr;
    logic                       w_idle;
    logic                       w_done;
    logic                       w_take;
    logic                       w_start;
    cbs_pkg::t_result           w_result;
    logic                       r_ovalid, n_ovalid;
    cbs_pkg::t_result           r_out;

    // Take config writes only while the engine is idle; a write empties the queue.
    assign o_cfg_ready = w_idle;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= cbs_pkg::RING_RST;
        end else if (w_cfg_wr) begin
            r_max <= i_cfg_data;
        end
    end

    // Clamp the ring size into 2..DEPTH.
    always_comb begin
        if (r_max < cbs_pkg::RING_MIN) begin
            w_ring = cbs_pkg::RING_MIN;
        end else if (32'(r_max) > DEPTH) begin
            w_ring = cbs_pkg::RING_W'(DEPTH);
        end else begin
            w_ring = r_max;
        end
    end

    // Hold off input words while a config write lands so the clear wins cleanly.
    assign s_axis_tready = w_idle && !i_cfg_valid;
    assign w_start       = s_axis_tvalid && s_axis_tready;

    cbs_engine #(.DEPTH(DEPTH)) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clr    (w_cfg_wr),
        .i_ring   (w_ring),
        .i_start  (w_start),
        .i_func   (s_axis_tuser),
        .i_value  ($signed(s_axis_tdata)),
        .o_idle   (w_idle),
        .o_done   (w_done),
        .i_take   (w_take),
        .o_result (w_result)
    );

    // Output register: drain the engine whenever the slot is free or emptying,
    // so the engine can start the next word while a result waits here.
    assign w_take = w_done && (!r_ovalid || m_axis_tready);

    always_comb begin
        n_ovalid = r_ovalid;
        if (w_take) begin
            n_ovalid = 1'b1;
        end else if (m_axis_tready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
        end
        if (w_take) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'b0000, r_out.occupancy, r_out.value};
    assign m_axis_tuser  = r_out.status;

endmodule
